/* src/gsa_pkg.sv */
// Shared constants, node record type and row addressing for the suffix automaton.
package gsa_pkg;

	localparam int MAX_NODES = 4096;
	localparam int NODE_W    = 12;
	localparam int ALPHA     = 27;
	localparam int SYM_W     = 5;
	localparam int TADDR_W   = 17;
	localparam int CNT_W     = 25;
	localparam int STEP_W    = 13;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [NODE_W-1:0] ROOT     = NODE_W'(1);

	typedef struct packed {
		logic [NODE_W-1:0] link;
		logic [NODE_W-1:0] len;
	} node_t;

	function automatic logic [TADDR_W-1:0] row_addr(input logic [NODE_W-1:0] node,
			input logic [SYM_W-1:0] col);
		return TADDR_W'(node) * TADDR_W'(ALPHA) + TADDR_W'(col);
	endfunction

endpackage

/* src/generalized_suffix_automaton.sv */
// Generalized suffix automaton built in a transition memory and a node memory.
//
// Input channel (in_valid/in_ready) takes one word: command, symbol, prev_node.
// command 0 extends the automaton from prev_node by symbol and returns the node
// for the extended string (0 when the request is invalid, store_full set when
// the node store is exhausted). command 1 returns the distinct substring count.
// Output channel (out_valid/out_ready) returns one word per input word.
// Words are worked one at a time; in_ready is high only when no word is active.
// An extend that finds an existing node goes straight to its result; otherwise a
// fresh row is cleared, suffix links are walked, and a clone row copy follows
// when needed, each worked through the transition memory. A count reads, for
// each node, the length of the node and then the length of its link target
// through the node memory read port.
// After reset the root row is swept to zero before in_ready rises.
// A stalled receiver holds the result in the output register; the next word is
// still taken and worked, and waits for the output register before it finishes.
module generalized_suffix_automaton (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic [gsa_pkg::SYM_W-1:0]  symbol,
	input  logic [gsa_pkg::NODE_W-1:0] prev_node,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [gsa_pkg::NODE_W-1:0] new_node,
	output logic [gsa_pkg::CNT_W-1:0]  distinct_count,
	output logic                       store_full
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_INIT = 5'd1;
	localparam logic [4:0] S_E1   = 5'd2;
	localparam logic [4:0] S_E2   = 5'd3;
	localparam logic [4:0] S_CLR  = 5'd4;
	localparam logic [4:0] S_W1R  = 5'd5;
	localparam logic [4:0] S_W1D  = 5'd6;
	localparam logic [4:0] S_QD   = 5'd7;
	localparam logic [4:0] S_CPR  = 5'd8;
	localparam logic [4:0] S_CPW  = 5'd9;
	localparam logic [4:0] S_NW1  = 5'd10;
	localparam logic [4:0] S_NW2  = 5'd11;
	localparam logic [4:0] S_NW3  = 5'd12;
	localparam logic [4:0] S_W2R  = 5'd13;
	localparam logic [4:0] S_W2D  = 5'd14;
	localparam logic [4:0] S_C0   = 5'd15;
	localparam logic [4:0] S_C1   = 5'd16;
	localparam logic [4:0] S_C2   = 5'd17;
	localparam logic [4:0] S_DONE = 5'd18;

	localparam logic [gsa_pkg::SYM_W-1:0]  LAST_COL = gsa_pkg::SYM_W'(gsa_pkg::ALPHA - 1);
	localparam logic [gsa_pkg::STEP_W-1:0] STEP_LIM = gsa_pkg::STEP_W'(gsa_pkg::MAX_NODES);

	// memories
	logic [gsa_pkg::NODE_W-1:0] tmem [gsa_pkg::MAX_NODES*gsa_pkg::ALPHA];
	gsa_pkg::node_t             nmem [gsa_pkg::MAX_NODES];

	logic                        t_we, n_we;
	logic [gsa_pkg::TADDR_W-1:0] t_raddr, t_waddr;
	logic [gsa_pkg::NODE_W-1:0]  t_wdata, t_rdata, n_raddr, n_waddr;
	gsa_pkg::node_t              n_wdata, n_rdata, nd;
	logic                        nzero_q;

	// control and working registers
	logic [4:0]                  state_q;
	logic [gsa_pkg::NODE_W-1:0]  node_count_q, from_q, hit_q, made_q, p_q, q_q, clone_q;
	logic [gsa_pkg::NODE_W-1:0]  lenfrom_q, lenmade_q, lenp_q, lenq_q, linkq_q, lenclone_q;
	logic [gsa_pkg::NODE_W-1:0]  a_q;
	logic [gsa_pkg::SYM_W-1:0]   sym_q, j_q;
	logic [gsa_pkg::STEP_W-1:0]  steps_q, i_q;
	logic [gsa_pkg::CNT_W-1:0]   total_q;
	logic [gsa_pkg::NODE_W-1:0]  res_node_q;
	logic [gsa_pkg::CNT_W-1:0]   res_cnt_q;
	logic                        res_full_q;

	logic                        accept;
	logic [gsa_pkg::CNT_W:0]     sum;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign nd       = nzero_q ? '0 : n_rdata;
	assign sum      = {1'b0, total_q} + (gsa_pkg::CNT_W+1)'(a_q - nd.len);

	// Synchronous memories with registered reads. Node reads of root and null give zero.
	always_ff @(posedge clk) begin
		if (t_we)
			tmem[t_waddr] <= t_wdata;
		t_rdata <= tmem[t_raddr];
		if (n_we)
			nmem[n_waddr] <= n_wdata;
		n_rdata <= nmem[n_raddr];
		nzero_q <= (n_raddr <= gsa_pkg::ROOT);
	end

	// Memory port steering per state.
	always_comb begin
		t_we    = 1'b0;
		t_waddr = gsa_pkg::row_addr(p_q, sym_q);
		t_wdata = '0;
		t_raddr = gsa_pkg::row_addr(p_q, sym_q);
		n_we    = 1'b0;
		n_waddr = made_q;
		n_wdata = '{link: clone_q, len: lenmade_q};
		n_raddr = p_q;
		case (state_q)
			S_IDLE: begin
				t_raddr = gsa_pkg::row_addr(prev_node, symbol);
				n_raddr = prev_node;
			end
			S_INIT: begin
				t_we    = 1'b1;
				t_waddr = gsa_pkg::row_addr(gsa_pkg::ROOT, j_q);
			end
			S_E1: n_raddr = t_rdata;
			S_CLR: begin
				t_we    = 1'b1;
				t_waddr = gsa_pkg::row_addr(made_q, j_q);
			end
			S_W1R: begin
				if (p_q == '0) begin
					n_we    = 1'b1;
					n_wdata = '{link: gsa_pkg::ROOT, len: lenmade_q};
				end
			end
			S_W1D: begin
				n_raddr = t_rdata;
				if (t_rdata == '0 && steps_q < STEP_LIM) begin
					t_we    = 1'b1;
					t_wdata = made_q;
				end
			end
			S_QD: begin
				if (nd.len == gsa_pkg::NODE_W'(lenp_q + 1'b1)) begin
					n_we    = 1'b1;
					n_wdata = '{link: q_q, len: lenmade_q};
				end
			end
			S_CPR: t_raddr = gsa_pkg::row_addr(q_q, j_q);
			S_CPW: begin
				t_we    = 1'b1;
				t_waddr = gsa_pkg::row_addr(clone_q, j_q);
				t_wdata = t_rdata;
			end
			S_NW1: n_we = (p_q != from_q);
			S_NW2: begin
				n_we    = 1'b1;
				n_waddr = clone_q;
				n_wdata = '{link: linkq_q, len: lenclone_q};
			end
			S_NW3: begin
				n_we    = 1'b1;
				n_waddr = q_q;
				n_wdata = '{link: clone_q, len: lenq_q};
			end
			S_W2D: begin
				if (t_rdata == q_q && steps_q < STEP_LIM) begin
					t_we    = 1'b1;
					t_wdata = clone_q;
				end
			end
			S_C0: n_raddr = i_q[gsa_pkg::NODE_W-1:0];
			S_C1: n_raddr = nd.link;
			default: ;
		endcase
	end

	// Sequencer: walk links, clear and copy rows, sweep nodes for the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			j_q          <= '0;
			node_count_q <= gsa_pkg::ROOT;
			out_valid    <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_DONE)
				out_valid <= 1'b0;
			case (state_q)
				S_INIT: begin
					j_q <= j_q + 1'b1;
					if (j_q == LAST_COL)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						res_node_q <= '0;
						res_cnt_q  <= '0;
						res_full_q <= 1'b0;
						sym_q      <= symbol;
						from_q     <= prev_node;
						if (command) begin
							i_q     <= gsa_pkg::STEP_W'(2);
							total_q <= '0;
							state_q <= S_C0;
						end else if (symbol >= gsa_pkg::SYM_W'(gsa_pkg::ALPHA)
								|| prev_node == '0 || prev_node > node_count_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_E1;
						end
					end
				end
				S_E1: begin
					hit_q     <= t_rdata;
					lenfrom_q <= nd.len;
					state_q   <= S_E2;
				end
				S_E2: begin
					if (hit_q != '0 && nd.len == gsa_pkg::NODE_W'(lenfrom_q + 1'b1)) begin
						res_node_q <= hit_q;
						state_q    <= S_DONE;
					end else if ({1'b0, node_count_q} + 13'd2 >= STEP_LIM) begin
						res_full_q <= 1'b1;
						state_q    <= S_DONE;
					end else begin
						made_q       <= node_count_q + 1'b1;
						node_count_q <= node_count_q + 1'b1;
						lenmade_q    <= lenfrom_q + 1'b1;
						p_q          <= from_q;
						steps_q      <= '0;
						j_q          <= '0;
						state_q      <= S_CLR;
					end
				end
				S_CLR: begin
					j_q <= j_q + 1'b1;
					if (j_q == LAST_COL)
						state_q <= S_W1R;
				end
				S_W1R: begin
					if (p_q == '0) begin
						res_node_q <= made_q;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_W1D;
					end
				end
				S_W1D: begin
					if (t_rdata == '0 && steps_q < STEP_LIM) begin
						p_q     <= nd.link;
						steps_q <= steps_q + 1'b1;
						state_q <= S_W1R;
					end else begin
						q_q     <= t_rdata;
						lenp_q  <= nd.len;
						state_q <= S_QD;
					end
				end
				S_QD: begin
					lenq_q  <= nd.len;
					linkq_q <= nd.link;
					if (nd.len == gsa_pkg::NODE_W'(lenp_q + 1'b1)) begin
						res_node_q <= made_q;
						state_q    <= S_DONE;
					end else begin
						if (p_q == from_q) begin
							clone_q <= made_q;
						end else begin
							clone_q      <= node_count_q + 1'b1;
							node_count_q <= node_count_q + 1'b1;
						end
						lenclone_q <= lenp_q + 1'b1;
						j_q        <= '0;
						state_q    <= S_CPR;
					end
				end
				S_CPR: state_q <= S_CPW;
				S_CPW: begin
					j_q     <= j_q + 1'b1;
					state_q <= (j_q == LAST_COL) ? S_NW1 : S_CPR;
				end
				S_NW1: state_q <= S_NW2;
				S_NW2: state_q <= S_NW3;
				S_NW3: begin
					steps_q <= '0;
					state_q <= S_W2R;
				end
				S_W2R: begin
					if (p_q == '0) begin
						res_node_q <= made_q;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_W2D;
					end
				end
				S_W2D: begin
					if (t_rdata == q_q && steps_q < STEP_LIM) begin
						p_q     <= nd.link;
						steps_q <= steps_q + 1'b1;
						state_q <= S_W2R;
					end else begin
						res_node_q <= made_q;
						state_q    <= S_DONE;
					end
				end
				S_C0: begin
					if (i_q > {1'b0, node_count_q}) begin
						res_cnt_q <= total_q;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_C1;
					end
				end
				S_C1: begin
					a_q     <= nd.len;
					state_q <= S_C2;
				end
				S_C2: begin
					// add len minus link length, saturate at the top of the range
					if (a_q > nd.len)
						total_q <= (sum > {1'b0, gsa_pkg::COUNT_MAX}) ? gsa_pkg::COUNT_MAX
						                                              : sum[gsa_pkg::CNT_W-1:0];
					i_q     <= i_q + 1'b1;
					state_q <= S_C0;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid || out_ready)) begin
			new_node       <= res_node_q;
			distinct_count <= res_cnt_q;
			store_full     <= res_full_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, node_count_q} < STEP_LIM)
		else $error("node count beyond store");
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_full |-> new_node == '0 && distinct_count == '0)
		else $error("refused extend carries data");
	a_row_write: assert property (@(posedge clk) disable iff (!arst_n)
		t_we |-> t_waddr >= gsa_pkg::TADDR_W'(gsa_pkg::ALPHA))
		else $error("write to null row");
	a_node_write: assert property (@(posedge clk) disable iff (!arst_n)
		n_we |-> n_waddr > gsa_pkg::ROOT && n_waddr <= node_count_q)
		else $error("node write outside live nodes");
`endif

endmodule

/* verif/generalized_suffix_automaton_tb.sv */
// Self-checking testbench for the generalized suffix automaton, with its own shadow automaton.
module generalized_suffix_automaton_tb;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int LONG_HOLD      = 400;
	localparam int RANDOM_WORDS   = 750;

	typedef enum logic {CMD_EXTEND = 1'b0, CMD_COUNT = 1'b1} command_t;

	typedef struct {
		logic [gsa_pkg::NODE_W-1:0] node;
		logic [gsa_pkg::CNT_W-1:0]  total;
		logic                       full;
	} answer_t;

	// Shadow automaton: mirrors the node store and transition rows, predicts each answer
	// when its word is taken, and checks answers in arrival order.
	class automaton_mirror;
		int unsigned rows [gsa_pkg::MAX_NODES*gsa_pkg::ALPHA];
		int unsigned links [gsa_pkg::MAX_NODES];
		int unsigned lengths [gsa_pkg::MAX_NODES];
		int unsigned nodes;
		answer_t     awaited [$];
		int          mismatches;

		function new();
			nodes = 1;
			mismatches = 0;
		endfunction

		function bit store_exhausted();
			return nodes + 2 >= gsa_pkg::MAX_NODES;
		endfunction

		function answer_t grow(int unsigned s, int unsigned from);
			answer_t     a;
			int unsigned hit, made, p, q, twin, steps;
			a = '{node: '0, total: '0, full: 1'b0};
			if (s >= gsa_pkg::ALPHA || from == 0 || from > nodes || from >= gsa_pkg::MAX_NODES)
				return a;
			hit = rows[from*gsa_pkg::ALPHA + s];
			if (hit != 0 && lengths[hit] == lengths[from] + 1) begin
				a.node = gsa_pkg::NODE_W'(hit);
				return a;
			end
			if (store_exhausted()) begin
				a.full = 1'b1;
				return a;
			end
			nodes++;
			made = nodes;
			lengths[made] = lengths[from] + 1;
			p = from;
			steps = 0;
			// lay the new edge along the suffix chain until an edge exists
			while (p != 0 && rows[p*gsa_pkg::ALPHA + s] == 0 && steps < gsa_pkg::MAX_NODES) begin
				rows[p*gsa_pkg::ALPHA + s] = made;
				p = links[p];
				steps++;
			end
			if (p == 0) begin
				links[made] = 1;
			end else begin
				q = rows[p*gsa_pkg::ALPHA + s];
				if (lengths[q] == lengths[p] + 1) begin
					links[made] = q;
				end else begin
					// the new node stands in as the clone when the walk stopped at from
					if (p == from) begin
						twin = made;
					end else begin
						nodes++;
						twin = nodes;
					end
					lengths[twin] = lengths[p] + 1;
					if (twin != q)
						for (int c = 0; c < gsa_pkg::ALPHA; c++)
							rows[twin*gsa_pkg::ALPHA + c] = rows[q*gsa_pkg::ALPHA + c];
					if (p != from) links[made] = twin;
					links[twin] = links[q];
					if (q != 0) links[q] = twin;
					steps = 0;
					while (p != 0 && rows[p*gsa_pkg::ALPHA + s] == q
							&& steps < gsa_pkg::MAX_NODES) begin
						rows[p*gsa_pkg::ALPHA + s] = twin;
						p = links[p];
						steps++;
					end
				end
			end
			a.node = gsa_pkg::NODE_W'(made);
			return a;
		endfunction

		function answer_t tally();
			answer_t     a;
			longint      sum;
			int unsigned lo;
			sum = 0;
			for (int unsigned i = 2; i <= nodes && i < gsa_pkg::MAX_NODES; i++) begin
				lo = lengths[links[i]];
				if (lengths[i] > lo) sum += lengths[i] - lo;
				if (sum > gsa_pkg::COUNT_MAX) sum = gsa_pkg::COUNT_MAX;
			end
			a = '{node: '0, total: gsa_pkg::CNT_W'(sum), full: 1'b0};
			return a;
		endfunction

		function answer_t note_word(command_t cmd, logic [gsa_pkg::SYM_W-1:0] sym,
				logic [gsa_pkg::NODE_W-1:0] prev);
			answer_t a;
			if (cmd == CMD_EXTEND) a = grow(sym, prev);
			else a = tally();
			awaited.push_back(a);
			return a;
		endfunction

		function void check_result(logic [gsa_pkg::NODE_W-1:0] node,
				logic [gsa_pkg::CNT_W-1:0] total, logic full);
			answer_t a;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected answer: node %0d count %0d full %0d",
						node, total, full);
				return;
			end
			a = awaited.pop_front();
			if (node !== a.node || total !== a.total || full !== a.full) begin
				mismatches++;
				if (mismatches <= 10)
					$display("answer mismatch: expected node %0d count %0d full %0d, got %0d %0d %0d",
						a.node, a.total, a.full, node, total, full);
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic                       command;
	logic [gsa_pkg::SYM_W-1:0]  symbol;
	logic [gsa_pkg::NODE_W-1:0] prev_node;
	logic                       out_valid;
	logic                       out_ready;
	logic [gsa_pkg::NODE_W-1:0] new_node;
	logic [gsa_pkg::CNT_W-1:0]  distinct_count;
	logic                       store_full;

	automaton_mirror mirror = new();

	// idling switch for both sides, and the one-off long hold of the receiver
	bit calm;
	bit hold_request;
	int idle_cycles;

	// tip of the current string and the last word that created a node
	logic [gsa_pkg::NODE_W-1:0] tip;
	logic [gsa_pkg::NODE_W-1:0] made_from;
	logic [gsa_pkg::SYM_W-1:0]  made_with;

	generalized_suffix_automaton dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.symbol         (symbol),
		.prev_node      (prev_node),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.new_node       (new_node),
		.distinct_count (distinct_count),
		.store_full     (store_full)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one word, hold it until taken, and predict its answer on acceptance.
	// Called and returning at a falling edge.
	task automatic send_word(input command_t cmd, input logic [gsa_pkg::SYM_W-1:0] sym,
			input logic [gsa_pkg::NODE_W-1:0] prev, output answer_t a);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		symbol    <= sym;
		prev_node <= prev;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		a = mirror.note_word(cmd, sym, prev);
		@(negedge clk);
	endtask

	// Extend and follow the string: advance the tip when a node comes back.
	task automatic extend_word(input logic [gsa_pkg::SYM_W-1:0] sym,
			input logic [gsa_pkg::NODE_W-1:0] prev);
		answer_t           a;
		int unsigned       nodes_prior;
		nodes_prior = mirror.nodes;
		send_word(CMD_EXTEND, sym, prev, a);
		if (a.node != 0) begin
			tip = a.node;
			if (mirror.nodes != nodes_prior) begin
				made_from = prev;
				made_with = sym;
			end
		end
	endtask

	task automatic count_word();
		answer_t a;
		send_word(CMD_COUNT, gsa_pkg::SYM_W'($urandom), gsa_pkg::NODE_W'($urandom), a);
	endtask

	// Receiver: ready drops for random stretches; one long hold on request.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (calm || $urandom_range(0, 99) < 70) begin
				out_ready <= 1'b1;
			end else begin
				stall = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 50);
				out_ready <= 1'b0;
			end
		end
	end

	// Check answers on the edge where they are taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			mirror.check_result(new_node, distinct_count, store_full);
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("[generalized_suffix_automaton] ERROR");
			$finish;
		end
	end

	initial begin
		int r;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		command      = CMD_EXTEND;
		symbol       = '0;
		prev_node    = gsa_pkg::ROOT;
		out_ready    = 1'b0;
		calm         = 1'b0;
		hold_request = 1'b0;
		tip          = gsa_pkg::ROOT;
		made_from    = gsa_pkg::ROOT;
		made_with    = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty count, bad requests, a hit, a clone and the same-parent clone
		count_word();
		extend_word(5'd0, gsa_pkg::NODE_W'(0));
		extend_word(5'd0, gsa_pkg::NODE_W'(4095));
		extend_word(5'd27, gsa_pkg::ROOT);
		extend_word(5'd31, gsa_pkg::ROOT);
		extend_word(5'd26, gsa_pkg::NODE_W'(2));
		tip = gsa_pkg::ROOT;
		extend_word(5'd0, tip);
		extend_word(5'd0, gsa_pkg::ROOT);
		extend_word(5'd1, tip);
		extend_word(5'd0, tip);
		extend_word(5'd0, tip);
		extend_word(5'd1, tip);
		count_word();
		extend_word(5'd1, gsa_pkg::ROOT);
		extend_word(5'd26, gsa_pkg::ROOT);
		extend_word(5'd26, tip);
		extend_word(5'd0, gsa_pkg::ROOT);
		extend_word(5'd1, tip);
		count_word();
		extend_word(5'd0, gsa_pkg::NODE_W'(mirror.nodes + 1));
		count_word();

		// random: mostly strings over a small alphabet, with branches, noise and counts
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 150 == 0) calm = ($urandom_range(0, 2) == 0);
			if (n == 200) hold_request = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 4)
				count_word();
			else if (r < 7)
				extend_word(gsa_pkg::SYM_W'($urandom_range(27, 31)), gsa_pkg::NODE_W'($urandom));
			else if (r < 10)
				extend_word(gsa_pkg::SYM_W'($urandom_range(0, 26)), gsa_pkg::NODE_W'($urandom));
			else if (r < 16)
				extend_word(gsa_pkg::SYM_W'($urandom_range(0, 2)), gsa_pkg::ROOT);
			else if (r < 26)
				extend_word(gsa_pkg::SYM_W'($urandom_range(0, 2)),
					gsa_pkg::NODE_W'($urandom_range(1, mirror.nodes)));
			else if (r < 34)
				extend_word(gsa_pkg::SYM_W'($urandom_range(0, 26)), tip);
			else
				extend_word(gsa_pkg::SYM_W'($urandom_range(0, 2)), tip);
		end
		calm = 1'b0;

		// tail: repeat the last creating word, which must now hit, then noise and a count
		count_word();
		extend_word(gsa_pkg::SYM_W'($urandom_range(0, 26)), tip);
		extend_word(5'd26, gsa_pkg::NODE_W'($urandom_range(1, mirror.nodes)));
		extend_word(made_with, made_from);
		extend_word(5'd29, gsa_pkg::ROOT);
		count_word();

		in_valid <= 1'b0;
		while (mirror.awaited.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.awaited.size() == 0)
			$display("[generalized_suffix_automaton] OK");
		else
			$display("[generalized_suffix_automaton] ERROR");
		$finish;
	end

endmodule
